### design/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Delayed implication, disabled while reset is asserted.
`define ASSERT_DLY2(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mts_pkg.sv
package mts_pkg;

  // Width of a memory word.
  localparam int DATA_WIDTH = 16;

  // Number of background patterns in one full test.
  localparam logic [2:0] NUM_PATTERNS = 3'd5;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // Kind of an input transaction.
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  // Command or verdict code of one result.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_WRITE = 3'd1,
    OP_READ  = 3'd2,
    OP_PASS  = 3'd3,
    OP_FAIL  = 3'd4
  } op_t;

  // Test sequencer phase.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WRITE = 3'd1,
    PH_UP    = 3'd2,
    PH_DOWN  = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_START = 1'b0,
    REG_END   = 1'b1
  } cfg_reg_t;

  // Background pattern for a pattern index; indexes past the list read as zero.
  function automatic word_t pattern_word(input logic [2:0] idx);
    word_t w;
    unique case (idx)
      3'd0:    w = 16'hFF00;
      3'd1:    w = 16'h0F0F;
      3'd2:    w = 16'h3333;
      3'd3:    w = 16'h5555;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

### design/march_memory_test_sequencer.sv
// March memory test sequencer for a memory built-in self-test.
// Input channel (in_): one transaction per step. in_tuser is the kind flag
// (0 starts a new test over [start, end), 1 steps the test) and in_tdata
// returns the read data for the previous read command.
// Result channel (out_): exactly one transaction per input transaction, in
// order. out_tuser carries the op (a write or read command, op none, or a
// passed or failed verdict); out_tdata carries address and data words.
// Configuration channel (cfg_): writes the start and end word addresses;
// it is always ready and should only be written while the block is idle.
// An accepted item passes from the input register through the next-state
// logic into the result register, where the receiver can take it.
// Throughput is one item per cycle while results are taken, set by the
// single next-state pass between the input register and the result register.
// When the receiver stalls, the result register holds and the input
// register takes one more transaction; after that in_tready drops until
// the result is taken.
// Synchronous reset clears both pipeline valids, the sequencer state
// (idle, pattern zero, address zero, no read pending) and both address
// registers.
module march_memory_test_sequencer
  import mts_pkg::*;
#(
  parameter int ADDR_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_WIDTH-1:0] in_tdata,   // read_data
  input  logic                  in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2:0]            out_tuser,  // op
  output logic [((ADDR_WIDTH+3*DATA_WIDTH+7)/8)*8-1:0] out_tdata,  // address, write_data,
                                                                  // expected_data,
                                                                  // actual_data, zero fill
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_addr,
  input  logic [ADDR_WIDTH-1:0] cfg_data
);

  localparam int OUT_BITS = ((ADDR_WIDTH + 3 * DATA_WIDTH + 7) / 8) * 8;
  localparam logic [ADDR_WIDTH-1:0] ADDR_ONE = ADDR_WIDTH'(1);

  logic [ADDR_WIDTH-1:0] start_r, end_r;

  // Input register.
  logic                  in_valid_r;
  logic                  kind_r;
  word_t                 rdata_r;

  // Sequencer state.
  phase_t                phase_r, phase_nxt;
  logic [2:0]            pat_idx_r, pat_idx_nxt;
  logic [ADDR_WIDTH-1:0] cur_r, cur_nxt;
  logic                  await_r, await_nxt;

  // Result register.
  logic                  out_valid_r;
  op_t                   op_r, op_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  word_t                 wd_r, wd_nxt;
  word_t                 exp_r, exp_nxt;
  word_t                 act_r, act_nxt;

  logic                  advance;
  logic                  range_ok;
  logic                  cur_below_end;
  word_t                 pat;
  word_t                 expect_word;

  // The input stage moves forward whenever the result register is free.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
    end else if (cfg_valid) begin
      if (cfg_addr == REG_START) begin
        start_r <= cfg_data;
      end else begin
        end_r <= cfg_data;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r  <= in_tuser;
      rdata_r <= in_tdata;
    end
  end

  assign range_ok      = start_r < end_r;
  assign cur_below_end = cur_r < end_r;
  assign pat           = pattern_word(pat_idx_r);
  assign expect_word   = (phase_r == PH_UP) ? pat : ~pat;

  // Next state and result for the item in the input register.
  always_comb begin
    phase_nxt   = phase_r;
    pat_idx_nxt = pat_idx_r;
    cur_nxt     = cur_r;
    await_nxt   = 1'b0;
    op_nxt      = OP_NONE;
    addr_nxt    = '0;
    wd_nxt      = '0;
    exp_nxt     = '0;
    act_nxt     = '0;
    priority if (kind_r == KIND_START) begin
      // Start a new test from the first pattern.
      pat_idx_nxt = '0;
      if (range_ok) begin
        op_nxt    = OP_WRITE;
        addr_nxt  = start_r;
        wd_nxt    = pattern_word(3'd0);
        cur_nxt   = start_r + ADDR_ONE;
        phase_nxt = PH_WRITE;
      end else begin
        op_nxt    = OP_PASS;
        phase_nxt = PH_DONE;
      end
    end else if (await_r && (phase_r == PH_UP || phase_r == PH_DOWN)) begin
      // Check the returned word, then write back the next background.
      if (rdata_r != expect_word) begin
        op_nxt    = OP_FAIL;
        addr_nxt  = cur_r;
        exp_nxt   = expect_word;
        act_nxt   = rdata_r;
        phase_nxt = PH_DONE;
      end else begin
        op_nxt   = OP_WRITE;
        addr_nxt = cur_r;
        if (phase_r == PH_UP) begin
          wd_nxt  = ~pat;
          cur_nxt = cur_r + ADDR_ONE;
        end else begin
          wd_nxt = pat;
          if (cur_r == start_r) begin
            pat_idx_nxt = pat_idx_r + 3'd1;
            phase_nxt   = PH_WRITE;
            cur_nxt     = start_r;
          end else begin
            cur_nxt = cur_r - ADDR_ONE;
          end
        end
      end
    end else begin
      // Issue the next command of the current pass, skipping empty passes.
      unique case (phase_r)
        PH_WRITE: begin
          if (pat_idx_r >= NUM_PATTERNS) begin
            op_nxt    = OP_PASS;
            phase_nxt = PH_DONE;
          end else if (cur_below_end) begin
            op_nxt   = OP_WRITE;
            addr_nxt = cur_r;
            wd_nxt   = pat;
            cur_nxt  = cur_r + ADDR_ONE;
          end else if (range_ok) begin
            op_nxt    = OP_READ;
            addr_nxt  = start_r;
            cur_nxt   = start_r;
            phase_nxt = PH_UP;
            await_nxt = 1'b1;
          end else begin
            op_nxt    = OP_PASS;
            phase_nxt = PH_DONE;
          end
        end
        PH_UP: begin
          if (cur_below_end) begin
            op_nxt    = OP_READ;
            addr_nxt  = cur_r;
            await_nxt = 1'b1;
          end else if (range_ok) begin
            op_nxt    = OP_READ;
            addr_nxt  = end_r - ADDR_ONE;
            cur_nxt   = end_r - ADDR_ONE;
            phase_nxt = PH_DOWN;
            await_nxt = 1'b1;
          end else begin
            op_nxt    = OP_PASS;
            phase_nxt = PH_DONE;
          end
        end
        PH_DOWN: begin
          if (range_ok) begin
            op_nxt    = OP_READ;
            addr_nxt  = cur_r;
            await_nxt = 1'b1;
          end else begin
            op_nxt    = OP_PASS;
            phase_nxt = PH_DONE;
          end
        end
        default: begin
          op_nxt = OP_NONE;
        end
      endcase
    end
  end

  // Sequencer state advances once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pat_idx_r <= '0;
      cur_r     <= '0;
      await_r   <= 1'b0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      pat_idx_r <= pat_idx_nxt;
      cur_r     <= cur_nxt;
      await_r   <= await_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op_r   <= op_nxt;
      addr_r <= addr_nxt;
      wd_r   <= wd_nxt;
      exp_r  <= exp_nxt;
      act_r  <= act_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = op_r;
  assign out_tdata  = OUT_BITS'({act_r, exp_r, wd_r, addr_r});

endmodule

### design/mts_checker.sv
`include "assert_macros.svh"

module mts_checker
  import mts_pkg::*;
#(
  parameter int ADDR_WIDTH = 16
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [2:0] out_tuser,
  input logic [((ADDR_WIDTH+3*DATA_WIDTH+7)/8)*8-1:0] out_tdata
);

  localparam int OUT_BITS = ((ADDR_WIDTH + 3 * DATA_WIDTH + 7) / 8) * 8;

  logic                  in_acc;
  logic                  stalled;
  logic [OUT_BITS+2:0]   payload;

  assign in_acc  = in_tvalid && in_tready;
  assign stalled = out_tvalid && !out_tready;
  assign payload = {out_tdata, out_tuser};

  // A stalled result holds its payload.
  `ASSERT_NXT(a_out_hold, clk, rst_n, stalled, out_tvalid && $stable(payload), "result changed")

  // An accepted item is followed by a valid result at the result port: its own or an older one held by a stall.
  `ASSERT_DLY2(a_latency, clk, rst_n, in_acc, out_tvalid, "accepted item gave no result")

  // The block never refuses input while its result side is empty.
  `ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready, "input stalled while empty")

  // Reset leaves no result pending.
  `ASSERT_NXT_ALWAYS(a_reset_clear, clk, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind march_memory_test_sequencer mts_checker #(.ADDR_WIDTH(ADDR_WIDTH)) u_mts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
